// File: src/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared control word type for the segment intersection point pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

// File: src/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front
// Differences, cross products, range tests and scaled numerators.
// ----------------------------------------------------------------------------
module sip_front #(
  parameter int W = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [W-1:0]         x1_i,
  input  logic [W-1:0]         y1_i,
  input  logic [W-1:0]         x2_i,
  input  logic [W-1:0]         y2_i,
  input  logic [W-1:0]         x3_i,
  input  logic [W-1:0]         y3_i,
  input  logic [W-1:0]         x4_i,
  input  logic [W-1:0]         y4_i,
  output sip_pkg::ctl_t        ctl_o,
  output logic [W-1:0]         x1_o,
  output logic [W-1:0]         y1_o,
  output logic [2*W+1:0]       den_o,
  output logic [3*W+3:0]       nx_o,
  output logic [3*W+3:0]       ny_o
);

  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 3;
  localparam int H  = W + 1;

  // stage 1: differences
  logic                 v1_q, v2_q, v3_q, v4_q;
  logic signed [DW-1:0] dxa1_q, dya1_q, dxb1_q, dyb1_q, ox1_q, oy1_q;
  logic [W-1:0]         x1a_q, y1a_q, x1b_q, y1b_q, x1c_q, y1c_q, x1d_q, y1d_q;
  logic [W-1:0]         x1e_q, y1e_q;

  // stage 2: products
  logic signed [PW-1:0] p_den0_q, p_den1_q, p_na0_q, p_na1_q, p_nb0_q, p_nb1_q;
  logic signed [DW-1:0] dxa2_q, dya2_q, dxa3_q, dya3_q;

  // stage 3: sums
  logic signed [NW-1:0] den3_q, na3_q, nb3_q;

  // stage 4: sign normalisation
  logic signed [NW-1:0] den4_q, na4_q, nb4_q;
  logic [DW-1:0]        adx4_q, ady4_q;
  logic                 negx4_q, negy4_q;

  // stage 5: tests and partial products
  sip_pkg::ctl_t        ctl5_q;
  logic [2*H-1:0]       px_lo_q, px_hi_q, py_lo_q, py_hi_q;
  logic [2*W+1:0]       den5_q;

  // stage 6
  sip_pkg::ctl_t        ctl6_q;
  logic [3*W+3:0]       nx6_q, ny6_q;
  logic [2*W+1:0]       den6_q;

  logic hit5_d;

  assign hit5_d = (den4_q != '0) && !na4_q[NW-1] && !nb4_q[NW-1]
                  && (na4_q <= den4_q) && (nb4_q <= den4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      ctl5_q <= '0;
      ctl6_q <= '0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      ctl5_q <= '{valid: v4_q, hit: hit5_d, neg_x: negx4_q, neg_y: negy4_q};
      ctl6_q <= ctl5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dxa1_q <= $signed({x2_i[W-1], x2_i}) - $signed({x1_i[W-1], x1_i});
    dya1_q <= $signed({y2_i[W-1], y2_i}) - $signed({y1_i[W-1], y1_i});
    dxb1_q <= $signed({x4_i[W-1], x4_i}) - $signed({x3_i[W-1], x3_i});
    dyb1_q <= $signed({y4_i[W-1], y4_i}) - $signed({y3_i[W-1], y3_i});
    ox1_q  <= $signed({x1_i[W-1], x1_i}) - $signed({x3_i[W-1], x3_i});
    oy1_q  <= $signed({y1_i[W-1], y1_i}) - $signed({y3_i[W-1], y3_i});
    x1a_q  <= x1_i;
    y1a_q  <= y1_i;

    p_den0_q <= PW'(dyb1_q) * PW'(dxa1_q);
    p_den1_q <= PW'(dxb1_q) * PW'(dya1_q);
    p_na0_q  <= PW'(dxb1_q) * PW'(oy1_q);
    p_na1_q  <= PW'(dyb1_q) * PW'(ox1_q);
    p_nb0_q  <= PW'(dxa1_q) * PW'(oy1_q);
    p_nb1_q  <= PW'(dya1_q) * PW'(ox1_q);
    dxa2_q   <= dxa1_q;
    dya2_q   <= dya1_q;
    x1b_q    <= x1a_q;
    y1b_q    <= y1a_q;

    den3_q <= NW'(p_den0_q) - NW'(p_den1_q);
    na3_q  <= NW'(p_na0_q) - NW'(p_na1_q);
    nb3_q  <= NW'(p_nb0_q) - NW'(p_nb1_q);
    dxa3_q <= dxa2_q;
    dya3_q <= dya2_q;
    x1c_q  <= x1b_q;
    y1c_q  <= y1b_q;

    den4_q  <= den3_q[NW-1] ? -den3_q : den3_q;
    na4_q   <= den3_q[NW-1] ? -na3_q : na3_q;
    nb4_q   <= den3_q[NW-1] ? -nb3_q : nb3_q;
    adx4_q  <= dxa3_q[DW-1] ? DW'(-dxa3_q) : DW'(dxa3_q);
    ady4_q  <= dya3_q[DW-1] ? DW'(-dya3_q) : DW'(dya3_q);
    negx4_q <= dxa3_q[DW-1];
    negy4_q <= dya3_q[DW-1];
    x1d_q   <= x1c_q;
    y1d_q   <= y1c_q;

    px_lo_q <= (2*H)'(na4_q[H-1:0]) * (2*H)'(adx4_q);
    px_hi_q <= (2*H)'(na4_q[2*H-1:H]) * (2*H)'(adx4_q);
    py_lo_q <= (2*H)'(na4_q[H-1:0]) * (2*H)'(ady4_q);
    py_hi_q <= (2*H)'(na4_q[2*H-1:H]) * (2*H)'(ady4_q);
    den5_q  <= den4_q[2*W+1:0];
    x1e_q   <= x1d_q;
    y1e_q   <= y1d_q;

    nx6_q  <= {({px_hi_q, {H{1'b0}}} + (3*H)'(px_lo_q)), 1'b0};
    ny6_q  <= {({py_hi_q, {H{1'b0}}} + (3*H)'(py_lo_q)), 1'b0};
    den6_q <= den5_q;
    x1_o   <= x1e_q;
    y1_o   <= y1e_q;
  end

  assign ctl_o = ctl6_q;
  assign den_o = den6_q;
  assign nx_o  = nx6_q;
  assign ny_o  = ny6_q;

endmodule

// File: src/sip_div_cell.sv
// ----------------------------------------------------------------------------
// sip_div_cell
// One restoring division step for both coordinates, one quotient bit each.
// ----------------------------------------------------------------------------
module sip_div_cell #(
  parameter int W = 24,
  parameter int K = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sip_pkg::ctl_t ctl_i,
  input  logic [W-1:0]  x1_i,
  input  logic [W-1:0]  y1_i,
  input  logic [2*W+1:0] den_i,
  input  logic [3*W+3:0] rx_i,
  input  logic [3*W+3:0] ry_i,
  input  logic [W+1:0]  tx_i,
  input  logic [W+1:0]  ty_i,
  output sip_pkg::ctl_t ctl_o,
  output logic [W-1:0]  x1_o,
  output logic [W-1:0]  y1_o,
  output logic [2*W+1:0] den_o,
  output logic [3*W+3:0] rx_o,
  output logic [3*W+3:0] ry_o,
  output logic [W+1:0]  tx_o,
  output logic [W+1:0]  ty_o
);

  localparam int RW = 3 * W + 4;

  logic [RW-1:0] dsh;
  logic [RW:0]   dfx, dfy;

  assign dsh = RW'(den_i) << K;
  assign dfx = {1'b0, rx_i} - {1'b0, dsh};
  assign dfy = {1'b0, ry_i} - {1'b0, dsh};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_o  <= x1_i;
    y1_o  <= y1_i;
    den_o <= den_i;
    rx_o  <= dfx[RW] ? rx_i : dfx[RW-1:0];
    ry_o  <= dfy[RW] ? ry_i : dfy[RW-1:0];
    tx_o  <= {tx_i[W:0], !dfx[RW]};
    ty_o  <= {ty_i[W:0], !dfy[RW]};
  end

endmodule

// File: src/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// segment_intersection_point
// Exact parametric intersection of two segments, one pair per cycle.
// ----------------------------------------------------------------------------
// Path: start_i runs through the six front stages, the divider cells and an output register to done_o.
// Throughput: one word per cycle; busy_o stays low, six front stages and a
// chain of COORD_WIDTH + 2 divider cells each take a new word every cycle.
// Reset: rst_ni clears all valid flags; words in flight are dropped.
// The receiver cannot stall: each result shows for one cycle with done_o.
module segment_intersection_point #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [COORD_WIDTH-1:0] a_start_x_i,
  input  logic [COORD_WIDTH-1:0] a_start_y_i,
  input  logic [COORD_WIDTH-1:0] a_end_x_i,
  input  logic [COORD_WIDTH-1:0] a_end_y_i,
  input  logic [COORD_WIDTH-1:0] b_start_x_i,
  input  logic [COORD_WIDTH-1:0] b_start_y_i,
  input  logic [COORD_WIDTH-1:0] b_end_x_i,
  input  logic [COORD_WIDTH-1:0] b_end_y_i,
  output logic                   done_o,
  output logic                   hit_o,
  output logic [COORD_WIDTH-1:0] hit_x_o,
  output logic [COORD_WIDTH-1:0] hit_y_o
);

  localparam int W   = COORD_WIDTH;
  localparam int NC  = W + 2;
  localparam int LAT = W + 9;

  sip_pkg::ctl_t        ctl_c [0:NC];
  logic [W-1:0]         x1_c  [0:NC];
  logic [W-1:0]         y1_c  [0:NC];
  logic [2*W+1:0]       den_c [0:NC];
  logic [3*W+3:0]       rx_c  [0:NC];
  logic [3*W+3:0]       ry_c  [0:NC];
  logic [W+1:0]         tx_c  [0:NC];
  logic [W+1:0]         ty_c  [0:NC];

  sip_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .x1_i    (a_start_x_i),
    .y1_i    (a_start_y_i),
    .x2_i    (a_end_x_i),
    .y2_i    (a_end_y_i),
    .x3_i    (b_start_x_i),
    .y3_i    (b_start_y_i),
    .x4_i    (b_end_x_i),
    .y4_i    (b_end_y_i),
    .ctl_o   (ctl_c[0]),
    .x1_o    (x1_c[0]),
    .y1_o    (y1_c[0]),
    .den_o   (den_c[0]),
    .nx_o    (rx_c[0]),
    .ny_o    (ry_c[0])
  );

  assign tx_c[0] = '0;
  assign ty_c[0] = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    sip_div_cell #(.W(W), .K(NC - 1 - i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[i]),
      .x1_i   (x1_c[i]),
      .y1_i   (y1_c[i]),
      .den_i  (den_c[i]),
      .rx_i   (rx_c[i]),
      .ry_i   (ry_c[i]),
      .tx_i   (tx_c[i]),
      .ty_i   (ty_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .x1_o   (x1_c[i+1]),
      .y1_o   (y1_c[i+1]),
      .den_o  (den_c[i+1]),
      .rx_o   (rx_c[i+1]),
      .ry_o   (ry_c[i+1]),
      .tx_o   (tx_c[i+1]),
      .ty_o   (ty_c[i+1])
    );
  end

  logic [W+2:0]         tpx, tpy;
  logic signed [W+1:0]  offx, offy, sumx, sumy;
  logic                 done_q, hit_q;
  logic [W-1:0]         hx_q, hy_q;
  sip_pkg::ctl_t        ctl_l;

  assign ctl_l = ctl_c[NC];
  assign tpx   = {1'b0, tx_c[NC]} + (W+3)'(1);
  assign tpy   = {1'b0, ty_c[NC]} + (W+3)'(1);
  assign offx  = ctl_l.neg_x ? -$signed(tpx[W+2:1]) : $signed(tpx[W+2:1]);
  assign offy  = ctl_l.neg_y ? -$signed(tpy[W+2:1]) : $signed(tpy[W+2:1]);
  assign sumx  = $signed({{2{x1_c[NC][W-1]}}, x1_c[NC]}) + offx;
  assign sumy  = $signed({{2{y1_c[NC][W-1]}}, y1_c[NC]}) + offy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      done_q <= ctl_l.valid;
      hit_q  <= ctl_l.valid && ctl_l.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    hx_q <= ctl_l.hit ? sumx[W-1:0] : '0;
    hy_q <= ctl_l.hit ? sumy[W-1:0] : '0;
  end

  assign busy_o  = 1'b0;
  assign done_o  = done_q;
  assign hit_o   = hit_q;
  assign hit_x_o = hx_q;
  assign hit_y_o = hy_q;

`ifndef SYNTHESIS
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT)) else $error("result without a word");
  a_hit_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> done_o) else $error("hit outside a result");
  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (hit_x_o == '0 && hit_y_o == '0))
    else $error("miss carries a point");
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_l.valid && ctl_l.hit) |-> (tx_c[NC] <= (NC)'(2) << W))
    else $error("quotient out of range");
`endif

endmodule

// File: sim/segment_intersection_point_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_test
// Self-checking bench for the segment intersection point pipeline. Segment
// pairs are queued by an initial block and issued by a clocked driver; a
// clocked monitor compares each result with the prediction made when the
// pair was accepted. Directed pairs cover crossings, endpoint touches,
// parallel and degenerate segments and the coordinate extremes; random pairs
// follow, most of them built to cross.
// ----------------------------------------------------------------------------
module segment_intersection_point_test;

  localparam int CW = 24;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t x1, y1, x2, y2, x3, y3, x4, y4;
  } seg_pair_t;

  typedef struct {
    logic   hit;
    coord_t px;
    coord_t py;
  } crossing_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  logic   busy_o;
  coord_t a_start_x_i = '0, a_start_y_i = '0, a_end_x_i = '0, a_end_y_i = '0;
  coord_t b_start_x_i = '0, b_start_y_i = '0, b_end_x_i = '0, b_end_y_i = '0;
  logic   done_o;
  logic   hit_o;
  coord_t hit_x_o, hit_y_o;

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int        idle_pct = 0;
  bit        failed = 1'b0;

  segment_intersection_point #(.COORD_WIDTH(CW)) uut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .a_start_x_i, .a_start_y_i, .a_end_x_i, .a_end_y_i,
    .b_start_x_i, .b_start_y_i, .b_end_x_i, .b_end_y_i,
    .done_o, .hit_o, .hit_x_o, .hit_y_o
  );

  always #1 clk_i = ~clk_i;

  // start + round(num * delta / den), rounding half away from zero
  function automatic coord_t place_along(coord_t s, logic signed [127:0] num,
                                         logic signed [127:0] delta,
                                         logic signed [127:0] den);
    logic signed [127:0] prod, q, r;
    prod = num * (delta < 0 ? -delta : delta);
    q = prod / den;
    r = prod % den;
    if (2 * r >= den) q = q + 1;
    if (delta < 0) q = -q;
    return coord_t'(s + q);
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    logic signed [127:0] dxa, dya, dxb, dyb, ox, oy, den, na, nb;
    crossing_t c;
    dxa = p.x2 - p.x1; dya = p.y2 - p.y1;
    dxb = p.x4 - p.x3; dyb = p.y4 - p.y3;
    ox = p.x1 - p.x3;  oy = p.y1 - p.y3;
    den = dyb * dxa - dxb * dya;
    na = dxb * oy - dyb * ox;
    nb = dxa * oy - dya * ox;
    c = '{1'b0, '0, '0};
    if (den == 0) return c;
    if (den < 0) begin
      den = -den; na = -na; nb = -nb;
    end
    if (na < 0 || nb < 0 || na > den || nb > den) return c;
    c.hit = 1'b1;
    c.px = place_along(p.x1, na, dxa, den);
    c.py = place_along(p.y1, na, dya, den);
    return c;
  endfunction

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic add_pair(coord_t x1, y1, x2, y2, x3, y3, x4, y4);
    pending_pairs = {pending_pairs, seg_pair_t'{x1, y1, x2, y2, x3, y3, x4, y4}};
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && busy_o)) begin
      if (start_i) void'(pending_pairs.pop_front());
      if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start_i <= 1'b1;
        a_start_x_i <= pending_pairs[0].x1; a_start_y_i <= pending_pairs[0].y1;
        a_end_x_i <= pending_pairs[0].x2;   a_end_y_i <= pending_pairs[0].y2;
        b_start_x_i <= pending_pairs[0].x3; b_start_y_i <= pending_pairs[0].y3;
        b_end_x_i <= pending_pairs[0].x4;   b_end_y_i <= pending_pairs[0].y4;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) expected_crossings = {expected_crossings,
          predict_crossing(seg_pair_t'{a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i,
                                       b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i})};
      if (done_o) begin
        if (expected_crossings.size() == 0) begin
          $display("%0t: unexpected word hit=%b x=%0d y=%0d", $time,
                   hit_o, hit_x_o, hit_y_o);
          failed = 1'b1;
        end else begin
          want = expected_crossings.pop_front();
          if (hit_o !== want.hit || hit_x_o !== want.px || hit_y_o !== want.py) begin
            $display("%0t: expected hit=%b x=%0d y=%0d, got hit=%b x=%0d y=%0d",
                     $time, want.hit, want.px, want.py, hit_o, hit_x_o, hit_y_o);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    coord_t mx, mn, cx, cy, ax, ay, bx, by;
    int span;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    add_pair(0, 0, 2560, 2560, 0, 2560, 2560, 0);
    add_pair(0, 0, 256, 0, 256, 0, 256, 256);
    add_pair(0, 0, 256, 0, 0, 0, 0, 256);
    add_pair(0, 0, 256, 256, 256, 0, 0, 256);
    add_pair(0, 0, 256, 0, 0, 256, 256, 256);
    add_pair(0, 0, 256, 0, 128, 0, 512, 0);
    add_pair(5, 5, 5, 5, 0, 0, 10, 10);
    add_pair(0, 0, 256, 0, 512, -100, 512, 100);
    add_pair(0, 0, 256, 0, 100, 1, 100, 300);
    add_pair(mn, mn, mx, mx, mn, mx, mx, mn);
    add_pair(mx, mn, mn, mx, mn, mn, mx, mx);
    add_pair(mn, 0, mx, 0, 0, mn, 0, mx);
    add_pair(mx, mx, mn, mn, mx, mn, mn, mx);
    add_pair(0, 0, 3, 1, 1, 0, 2, 1);
    add_pair(-7, 3, 9, -5, -2, -9, 4, 11);
    add_pair(0, 0, 1, 0, 0, -1, 1, 1);
    add_pair(-1, -1, 1, 1, -1, 1, 1, -1);
    add_pair(mn, mn, mn, mn, mx, mx, mx, mx);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < 217; i++) begin
        span = (i % 3 == 0) ? 0 : (i % 3 == 1) ? 4000 : 16;
        if ($urandom_range(0, 9) < 7) begin
          // crossing-biased: two segments through a common point
          cx = rand_coord(span / 2); cy = rand_coord(span / 2);
          if (span == 0) begin cx = cx >>> 2; cy = cy >>> 2; end
          ax = rand_coord(span == 0 ? 2000000 : span / 2);
          ay = rand_coord(span == 0 ? 2000000 : span / 2);
          bx = rand_coord(span == 0 ? 2000000 : span / 2);
          by = rand_coord(span == 0 ? 2000000 : span / 2);
          add_pair(cx - ax, cy - ay, cx + ax / ($urandom_range(1, 2)),
                   cy + ay / ($urandom_range(1, 2)), cx + bx, cy + by,
                   cx - bx, cy - by);
        end else begin
          add_pair(rand_coord(span), rand_coord(span), rand_coord(span),
                   rand_coord(span), rand_coord(span), rand_coord(span),
                   rand_coord(span), rand_coord(span));
        end
      end
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 67 : 21;
      while (pending_pairs.size() > 0) @(posedge clk_i);
    end
    while (start_i || expected_crossings.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (!failed && expected_crossings.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

endmodule
